// File: rtl/core/mbet_pkg.sv
// ----------------------------------------------------------------------------
// mbet_pkg
// Shared types and constants for the escape-time pixel engine: payload
// structs, configuration register map and reset values, engine states.
// ----------------------------------------------------------------------------
package mbet_pkg;

    localparam int MAX_ITER_DEF   = 128;
    localparam int COORD_BITS_DEF = 32;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // job queue between mapper and iteration engine
    localparam int QUEUE_AW = 1;

    // pixel payload widths
    localparam int PIX_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_RE   = 3'd0,
        CFG_CENTER_IM   = 3'd1,
        CFG_STEP        = 3'd2,
        CFG_HALF_WIDTH  = 3'd3,
        CFG_HALF_HEIGHT = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] center_re;
        logic [31:0] center_im;
        logic [30:0] step;
        logic [11:0] half_width;
        logic [11:0] half_height;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        center_re:   32'hF4CC_CCCD,
        center_im:   32'h0000_0000,
        step:        31'd3355443,
        half_width:  12'd160,
        half_height: 12'd120
    };

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0]       iteration_count;
        logic             in_set;
        logic [PIX_W-1:0] out_x;
        logic [PIX_W-1:0] out_y;
    } t_pixel_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ACC,
        ST_DONE
    } t_iter_state;

endpackage

// File: rtl/core/mbet_map.sv
// ----------------------------------------------------------------------------
// mbet_map
// Front end: holds the view registers, takes pixels and maps each one to
// the point c = center + (pixel - half) * step, saturated to the coordinate
// range. Two stages: product, then add and clamp into the job queue.
// ----------------------------------------------------------------------------
module mbet_map #(
    parameter int COORD_BITS = mbet_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mbet_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mbet_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_push,
    input  mbet_pkg::t_pixel_in           i_pixel,
    output logic                          o_full,
    output logic                          o_job_valid,
    input  logic                          i_job_ready,
    output logic [2*COORD_BITS+23:0]      o_job
);
    import mbet_pkg::*;

    localparam int MW = ((COORD_BITS > 45) ? COORD_BITS : 45) + 1;
    localparam logic signed [MW-1:0] C_HI =
        {{(MW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [MW-1:0] C_LO =
        {{(MW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

    function automatic logic signed [MW-1:0] sat_coord(input logic signed [MW-1:0] v);
        if (v > C_HI) begin
            return C_HI;
        end
        if (v < C_LO) begin
            return C_LO;
        end
        return v;
    endfunction

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CENTER_RE:   r_cfg.center_re   <= i_cfg_data;
                CFG_CENTER_IM:   r_cfg.center_im   <= i_cfg_data;
                CFG_STEP:        r_cfg.step        <= i_cfg_data[30:0];
                CFG_HALF_WIDTH:  r_cfg.half_width  <= i_cfg_data[11:0];
                CFG_HALF_HEIGHT: r_cfg.half_height <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // stage 1: offset from the screen center times step
    logic signed [12:0] diff_x;
    logic signed [12:0] diff_y;
    logic signed [31:0] step_s;
    logic signed [44:0] prod_re;
    logic signed [44:0] prod_im;

    assign diff_x  = $signed({1'b0, i_pixel.pixel_x}) - $signed({1'b0, r_cfg.half_width});
    assign diff_y  = $signed({1'b0, i_pixel.pixel_y}) - $signed({1'b0, r_cfg.half_height});
    assign step_s  = $signed({1'b0, r_cfg.step});
    assign prod_re = diff_x * step_s;
    assign prod_im = diff_y * step_s;

    logic                     r_s1_valid;
    logic signed [44:0]       r_prod_re;
    logic signed [44:0]       r_prod_im;
    logic [PIX_W-1:0]         r_px;
    logic [PIX_W-1:0]         r_py;
    logic                     s1_free;

    assign s1_free = !r_s1_valid || i_job_ready;
    assign o_full  = !s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_push) begin
            r_prod_re <= prod_re;
            r_prod_im <= prod_im;
            r_px      <= i_pixel.pixel_x;
            r_py      <= i_pixel.pixel_y;
        end
    end

    // stage 2: center is clamped first, then the sum
    logic signed [MW-1:0] cen_re;
    logic signed [MW-1:0] cen_im;
    logic signed [MW-1:0] sum_re;
    logic signed [MW-1:0] sum_im;
    logic signed [MW-1:0] c_re;
    logic signed [MW-1:0] c_im;

    assign cen_re = sat_coord({{(MW-32){r_cfg.center_re[31]}}, r_cfg.center_re});
    assign cen_im = sat_coord({{(MW-32){r_cfg.center_im[31]}}, r_cfg.center_im});
    assign sum_re = cen_re + {{(MW-45){r_prod_re[44]}}, r_prod_re};
    assign sum_im = cen_im + {{(MW-45){r_prod_im[44]}}, r_prod_im};
    assign c_re   = sat_coord(sum_re);
    assign c_im   = sat_coord(sum_im);

    assign o_job_valid = r_s1_valid;
    assign o_job       = {c_re[COORD_BITS-1:0], c_im[COORD_BITS-1:0], r_px, r_py};

endmodule

// File: rtl/core/mbet_queue.sv
// ----------------------------------------------------------------------------
// mbet_queue
// Short job queue between the mapper and the iteration engine, so that
// each side can stall on its own.
// ----------------------------------------------------------------------------
module mbet_queue #(
    parameter int WIDTH = 2 * mbet_pkg::COORD_BITS_DEF + 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_valid,
    output logic             o_wr_ready,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_rd_valid,
    input  logic             i_rd_ready,
    output logic [WIDTH-1:0] o_rd_data
);
    import mbet_pkg::*;

    localparam int DEPTH = 1 << QUEUE_AW;

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                wr_en;
    logic                rd_en;

    assign o_wr_ready = (r_count != (QUEUE_AW+1)'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = i_rd_ready && o_rd_valid;
    assign o_rd_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/mbet_iter.sv
// ----------------------------------------------------------------------------
// mbet_iter
// Back end: runs z = z*z + c for one job at a time, each iteration as
// squares, then escape test and update, and holds the result in an
// output register until it is popped.
// ----------------------------------------------------------------------------
module mbet_iter #(
    parameter int MAX_ITER   = mbet_pkg::MAX_ITER_DEF,
    parameter int COORD_BITS = mbet_pkg::COORD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_job_valid,
    output logic                     o_job_ready,
    input  logic [2*COORD_BITS+23:0] i_job,
    output logic                     o_empty,
    input  logic                     i_pop,
    output mbet_pkg::t_pixel_out     o_result
);
    import mbet_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int JW   = 2 * CB + 24;
    localparam int CW   = $clog2(MAX_ITER + 1);
    localparam int CXW  = CW + 8;
    localparam int EW   = ((CB > 30) ? CB : 30) + 1;
    localparam int SW   = ((CB > 33) ? CB : 33) + 1;

    localparam logic signed [EW-1:0] TWO_POS = {{(EW-30){1'b0}}, 1'b1, {29{1'b0}}};
    localparam logic signed [EW-1:0] TWO_NEG = {{(EW-29){1'b1}}, {29{1'b0}}};
    localparam logic signed [60:0]   FOUR_SQ = {2'b00, 1'b1, {58{1'b0}}};
    localparam logic signed [SW-1:0] C_HI    = {{(SW-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [SW-1:0] C_LO    = {{(SW-CB+1){1'b1}}, {(CB-1){1'b0}}};

    function automatic logic signed [SW-1:0] sat_coord(input logic signed [SW-1:0] v);
        if (v > C_HI) begin
            return C_HI;
        end
        if (v < C_LO) begin
            return C_LO;
        end
        return v;
    endfunction

    t_iter_state r_state;
    t_iter_state n_state;

    logic signed [CB-1:0] r_cr;
    logic signed [CB-1:0] r_ci;
    logic signed [CB-1:0] r_x;
    logic signed [CB-1:0] r_y;
    logic [CW-1:0]        r_cnt;
    logic [PIX_W-1:0]     r_px;
    logic [PIX_W-1:0]     r_py;
    logic signed [59:0]   r_xx;
    logic signed [59:0]   r_yy;
    logic signed [59:0]   r_xy;
    logic                 r_out_valid;
    t_pixel_out           r_out;

    // magnitude test; once it passes, z fits in 30 bits
    logic signed [EW-1:0] x_e;
    logic signed [EW-1:0] y_e;
    logic                 big;
    logic signed [29:0]   x_n;
    logic signed [29:0]   y_n;
    logic                 cap;

    assign x_e = {{(EW-CB){r_x[CB-1]}}, r_x};
    assign y_e = {{(EW-CB){r_y[CB-1]}}, r_y};
    assign big = (x_e >= TWO_POS) || (x_e <= TWO_NEG) || (y_e >= TWO_POS) || (y_e <= TWO_NEG);
    assign x_n = x_e[29:0];
    assign y_n = y_e[29:0];
    assign cap = (r_cnt == CW'(MAX_ITER));

    // exact |z|^2 test and next z
    logic signed [60:0]   mag_sq;
    logic                 esc_sq;
    logic signed [60:0]   diff_sq;
    logic signed [32:0]   sh_re;
    logic signed [32:0]   sh_im;
    logic signed [SW-1:0] sum_re;
    logic signed [SW-1:0] sum_im;
    logic signed [SW-1:0] new_re;
    logic signed [SW-1:0] new_im;

    assign mag_sq  = {r_xx[59], r_xx} + {r_yy[59], r_yy};
    assign esc_sq  = (mag_sq >= FOUR_SQ);
    assign diff_sq = {r_xx[59], r_xx} - {r_yy[59], r_yy};
    assign sh_re   = diff_sq[60:28];
    // doubling of x*y folded into the shift
    assign sh_im   = r_xy[59:27];
    assign sum_re  = {{(SW-33){sh_re[32]}}, sh_re} + {{(SW-CB){r_cr[CB-1]}}, r_cr};
    assign sum_im  = {{(SW-33){sh_im[32]}}, sh_im} + {{(SW-CB){r_ci[CB-1]}}, r_ci};
    assign new_re  = sat_coord(sum_re);
    assign new_im  = sat_coord(sum_im);

    logic [CXW-1:0] cnt_x;
    logic           out_free;
    logic           load_job;
    logic           do_mult;
    logic           do_update;
    logic           out_load;

    assign cnt_x    = {8'd0, r_cnt};
    assign out_free = !r_out_valid || i_pop;

    always_comb begin
        n_state     = r_state;
        o_job_ready = 1'b0;
        load_job    = 1'b0;
        do_mult     = 1'b0;
        do_update   = 1'b0;
        out_load    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_job_ready = 1'b1;
                if (i_job_valid) begin
                    load_job = 1'b1;
                    n_state  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (cap || big) begin
                    n_state = ST_DONE;
                end else begin
                    do_mult = 1'b1;
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                if (esc_sq) begin
                    n_state = ST_DONE;
                end else begin
                    do_update = 1'b1;
                    n_state   = ST_CHECK;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_job) begin
            r_cr  <= i_job[JW-1 -: CB];
            r_ci  <= i_job[JW-CB-1 -: CB];
            r_px  <= i_job[2*PIX_W-1:PIX_W];
            r_py  <= i_job[PIX_W-1:0];
            r_x   <= '0;
            r_y   <= '0;
            r_cnt <= '0;
        end
        if (do_mult) begin
            r_xx <= x_n * x_n;
            r_yy <= y_n * y_n;
            r_xy <= x_n * y_n;
        end
        if (do_update) begin
            r_x   <= new_re[CB-1:0];
            r_y   <= new_im[CB-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.iteration_count <= cnt_x[7:0];
            r_out.in_set          <= cap;
            r_out.out_x           <= r_px;
            r_out.out_y           <= r_py;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

// File: rtl/core/mandelbrot_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time engine for the Mandelbrot set in signed Q4.28 fixed point.
// ----------------------------------------------------------------------------
// Input channel: drive i_pixel and raise i_push; a beat is taken at a clock
// edge where i_push is high and o_full is low.
// Result channel: while o_empty is low, o_result holds the oldest result
// (iteration count, in-set flag, echoed column and row); a beat is taken at
// an edge where i_pop is high and o_empty is low.
// Configuration: i_cfg_we writes i_cfg_data into the register at i_cfg_idx
// (center re, center im, step, half width, half height); write only while
// the block is idle. Unknown indexes are ignored.
// Flow: the mapper registers each product, then a job waits in a two-entry
// queue. The engine stops a pixel when |x| or |y| reaches 2, when the exact
// |z|^2 test escapes, or at the cap; each iteration squares, then tests and
// updates. One pixel is in the engine at a time.
// Reset: the queue and output register are emptied and the view registers
// return to their defaults. A stalled receiver holds the result; up to
// four further pixels are taken before o_full rises.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel #(
    parameter int MAX_ITER   = mbet_pkg::MAX_ITER_DEF,
    parameter int COORD_BITS = mbet_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mbet_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mbet_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_push,
    input  mbet_pkg::t_pixel_in             i_pixel,
    output logic                            o_full,
    output logic                            o_empty,
    input  logic                            i_pop,
    output mbet_pkg::t_pixel_out            o_result
);
    import mbet_pkg::*;

    localparam int JOB_W = 2 * COORD_BITS + 24;

    logic             map_valid;
    logic             map_ready;
    logic [JOB_W-1:0] map_job;
    logic             job_valid;
    logic             job_ready;
    logic [JOB_W-1:0] job;

    mbet_map #(
        .COORD_BITS (COORD_BITS)
    ) u_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_push      (i_push),
        .i_pixel     (i_pixel),
        .o_full      (o_full),
        .o_job_valid (map_valid),
        .i_job_ready (map_ready),
        .o_job       (map_job)
    );

    mbet_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (map_valid),
        .o_wr_ready (map_ready),
        .i_wr_data  (map_job),
        .o_rd_valid (job_valid),
        .i_rd_ready (job_ready),
        .o_rd_data  (job)
    );

    mbet_iter #(
        .MAX_ITER   (MAX_ITER),
        .COORD_BITS (COORD_BITS)
    ) u_iter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job       (job),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_result    (o_result)
    );

endmodule

// File: rtl/core/mbet_checker.sv
// ----------------------------------------------------------------------------
// mbet_checker
// Port-level checks for the escape-time engine, bound to the top level.
// ----------------------------------------------------------------------------
module mbet_checker #(
    parameter int MAX_ITER = mbet_pkg::MAX_ITER_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_full,
    input logic                 o_empty,
    input logic                 i_pop,
    input mbet_pkg::t_pixel_out o_result
);
    import mbet_pkg::*;

    // reset empties both sides
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result channel not empty after reset");

    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !o_full)
        else $error("input channel full after reset");

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_result))
        else $error("result changed while stalled");

    // in-set results carry the cap as their count
    a_in_set_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_result.in_set |-> o_result.iteration_count == 8'(MAX_ITER))
        else $error("in-set result with wrong count");

    // below 256 the count alone tells whether the cap was reached
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (MAX_ITER < 256) && !o_empty && !o_result.in_set
        |-> o_result.iteration_count != 8'(MAX_ITER))
        else $error("count at cap without in-set flag");

endmodule

bind mandelbrot_escape_time_pixel mbet_checker #(
    .MAX_ITER (MAX_ITER)
) u_mbet_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_full   (o_full),
    .o_empty  (o_empty),
    .i_pop    (i_pop),
    .o_result (o_result)
);
